FILE: rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the raycast textured column shader.
// ----------------------------------------------------------------------------
`default_nettype none
package rcs_pkg;
  localparam int TEX_SIZE     = 64;
  localparam int NUM_TEXTURES = 4;
  localparam int TEX_BITS     = $clog2(TEX_SIZE);
  localparam int FACE_BITS    = (NUM_TEXTURES > 1) ? $clog2(NUM_TEXTURES) : 1;
  localparam int INDEX_BITS   = 2 * TEX_BITS;
  localparam int ADDR_BITS    = FACE_BITS + INDEX_BITS;
  localparam int STORE_WORDS  = NUM_TEXTURES * TEX_SIZE * TEX_SIZE;

  localparam int NUM_BITS  = 32;
  localparam int DEN_BITS  = 24;
  localparam int REM_BITS  = 34;

  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_EYE_DISTANCE  = 2'd1;
  localparam logic [1:0] CFG_CEILING_COLOR = 2'd2;
  localparam logic [1:0] CFG_FLOOR_COLOR   = 2'd3;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef struct packed {
    logic        action;
    logic [10:0] column;
    logic [9:0]  row;
    logic [15:0] wall_hit;
    logic [1:0]  face;
    logic [11:0] texel_index;
    logic [31:0] texel_value;
  } side_t;
endpackage
`default_nettype wire

FILE: rtl/rcs_hdiv.sv
// ----------------------------------------------------------------------------
// rcs_hdiv
// Pipelined restoring divider for the wall height, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rcs_hdiv
  import rcs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_vld,
  input  wire side_t               in_side,
  input  wire logic [NUM_BITS-1:0] in_num,
  input  wire logic [DEN_BITS-1:0] in_den,
  output logic                     out_vld,
  output side_t                    out_side,
  output logic [NUM_BITS-1:0]      out_q
);
  logic                vld_r  [0:NUM_BITS-1];
  side_t               side_r [0:NUM_BITS-1];
  logic [NUM_BITS-1:0] num_r  [0:NUM_BITS-1];
  logic [DEN_BITS-1:0] den_r  [0:NUM_BITS-1];
  logic [DEN_BITS-1:0] rem_r  [0:NUM_BITS-1];
  logic [NUM_BITS-1:0] q_r    [0:NUM_BITS-1];

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic                vld_p;
    side_t               side_p;
    logic [NUM_BITS-1:0] num_p;
    logic [DEN_BITS-1:0] den_p;
    logic [DEN_BITS-1:0] rem_p;
    logic [NUM_BITS-1:0] q_p;
    logic [DEN_BITS:0]   trial;
    logic                ge;
    logic [DEN_BITS:0]   diff;

    if (s == 0) begin : g_first
      assign vld_p  = in_vld;
      assign side_p = in_side;
      assign num_p  = in_num;
      assign den_p  = in_den;
      assign rem_p  = '0;
      assign q_p    = '0;
    end else begin : g_next
      assign vld_p  = vld_r[s-1];
      assign side_p = side_r[s-1];
      assign num_p  = num_r[s-1];
      assign den_p  = den_r[s-1];
      assign rem_p  = rem_r[s-1];
      assign q_p    = q_r[s-1];
    end

    assign trial = {rem_p, num_p[NUM_BITS-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s] <= side_p;
        num_r[s]  <= {num_p[NUM_BITS-2:0], 1'b0};
        den_r[s]  <= den_p;
        rem_r[s]  <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        q_r[s]    <= {q_p[NUM_BITS-2:0], ge};
      end
    end
  end

  assign out_vld  = vld_r[NUM_BITS-1];
  assign out_side = side_r[NUM_BITS-1];
  assign out_q    = q_r[NUM_BITS-1];
endmodule
`default_nettype wire

FILE: rtl/rcs_trow.sv
// ----------------------------------------------------------------------------
// rcs_trow
// Wall band test and pipelined texel row divider.
// ----------------------------------------------------------------------------
`default_nettype none
module rcs_trow
  import rcs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic [10:0]         screen_height,
  input  wire logic                in_vld,
  input  wire side_t               in_side,
  input  wire logic [NUM_BITS-1:0] in_h,
  output logic                     out_vld,
  output side_t                    out_side,
  output logic                     out_wall,
  output logic                     out_ceil,
  output logic [TEX_BITS-1:0]      out_trow
);
  logic [REM_BITS-1:0] hh;
  logic [REM_BITS-1:0] y2;
  logic [REM_BITS-1:0] hx;
  logic                band;

  assign hh   = REM_BITS'({screen_height, 8'b0});
  assign y2   = REM_BITS'({in_side.row, 9'b0});
  assign hx   = REM_BITS'(in_h);
  assign band = (hx != '0) && (hh <= y2 + hx) && (y2 + REM_BITS'(512) <= hh + hx);

  logic                b_vld_r;
  side_t               b_side_r;
  logic                b_wall_r;
  logic                b_ceil_r;
  logic [REM_BITS-1:0] b_n_r;
  logic [REM_BITS-1:0] b_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side_r <= in_side;
      b_wall_r <= band;
      b_ceil_r <= {1'b0, in_side.row} < (screen_height >> 1);
      b_n_r    <= y2 + hx - hh;
      b_h_r    <= hx;
    end
  end

  logic                vld_r  [0:TEX_BITS-1];
  side_t               side_r [0:TEX_BITS-1];
  logic                wall_r [0:TEX_BITS-1];
  logic                ceil_r [0:TEX_BITS-1];
  logic [REM_BITS-1:0] rem_r  [0:TEX_BITS-1];
  logic [REM_BITS-1:0] h_r    [0:TEX_BITS-1];
  logic [TEX_BITS-1:0] q_r    [0:TEX_BITS-1];

  for (genvar s = 0; s < TEX_BITS; s++) begin : g_stage
    logic                vld_p;
    side_t               side_p;
    logic                wall_p;
    logic                ceil_p;
    logic [REM_BITS-1:0] rem_p;
    logic [REM_BITS-1:0] h_p;
    logic [TEX_BITS-1:0] q_p;
    logic [REM_BITS-1:0] trial;
    logic                ge;

    if (s == 0) begin : g_first
      assign vld_p  = b_vld_r;
      assign side_p = b_side_r;
      assign wall_p = b_wall_r;
      assign ceil_p = b_ceil_r;
      assign rem_p  = b_n_r;
      assign h_p    = b_h_r;
      assign q_p    = '0;
      assign trial  = rem_p;
    end else begin : g_next
      assign vld_p  = vld_r[s-1];
      assign side_p = side_r[s-1];
      assign wall_p = wall_r[s-1];
      assign ceil_p = ceil_r[s-1];
      assign rem_p  = rem_r[s-1];
      assign h_p    = h_r[s-1];
      assign q_p    = q_r[s-1];
      assign trial  = {rem_p[REM_BITS-2:0], 1'b0};
    end

    assign ge = trial >= h_p;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s] <= side_p;
        wall_r[s] <= wall_p;
        ceil_r[s] <= ceil_p;
        h_r[s]    <= h_p;
        rem_r[s]  <= ge ? trial - h_p : trial;
        q_r[s]    <= {q_p[TEX_BITS-2:0], ge};
      end
    end
  end

  assign out_vld  = vld_r[TEX_BITS-1];
  assign out_side = side_r[TEX_BITS-1];
  assign out_wall = wall_r[TEX_BITS-1];
  assign out_ceil = ceil_r[TEX_BITS-1];
  assign out_trow = q_r[TEX_BITS-1];
endmodule
`default_nettype wire

FILE: rtl/raycast_textured_column_shader_core.sv
// ----------------------------------------------------------------------------
// raycast_textured_column_shader_core
// Colors raycast pixels, wall pixels from four texture stores and the others
// with the ceiling or floor color. Pipeline: 32 height divider stages, band
// test, 6 texel row stages, texture read into the output register.
// Throughput: one word per cycle while not stalled; the whole pipeline holds
// while out_stall is high and an output word waits. Reset clears valid bits
// and loads the register defaults; texture contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module raycast_textured_column_shader_core
  import rcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [10:0] in_column,
  input  wire logic [9:0]  in_row,
  input  wire logic [23:0] in_wall_distance,
  input  wire logic [15:0] in_wall_hit,
  input  wire logic [1:0]  in_face,
  input  wire logic [11:0] in_texel_index,
  input  wire logic [31:0] in_texel_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      out_pixel_column,
  output logic [31:0]      out_pixel_color,
  output logic             out_in_wall,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic [10:0] screen_height_r;
  logic [15:0] eye_distance_r;
  logic [23:0] ceiling_color_r;
  logic [23:0] floor_color_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= 11'd480;
      eye_distance_r  <= 16'd277;
      ceiling_color_r <= '0;
      floor_color_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[10:0];
        CFG_EYE_DISTANCE:  eye_distance_r  <= cfg_data[15:0];
        CFG_CEILING_COLOR: ceiling_color_r <= cfg_data;
        CFG_FLOOR_COLOR:   floor_color_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  side_t       in_side;
  logic [23:0] den;

  assign in_side = '{action: in_action, column: in_column, row: in_row,
                     wall_hit: in_wall_hit, face: in_face,
                     texel_index: in_texel_index, texel_value: in_texel_value};
  assign den = (in_wall_distance == '0) ? 24'd1 : in_wall_distance;

  logic                d_vld;
  side_t               d_side;
  logic [NUM_BITS-1:0] d_h;

  rcs_hdiv u_hdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_side  (in_side),
    .in_num   ({eye_distance_r, 16'b0}),
    .in_den   (den),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_q    (d_h)
  );

  logic                t_vld;
  side_t               t_side;
  logic                t_wall;
  logic                t_ceil;
  logic [TEX_BITS-1:0] t_trow;

  rcs_trow u_trow (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .screen_height (screen_height_r),
    .in_vld        (d_vld),
    .in_side       (d_side),
    .in_h          (d_h),
    .out_vld       (t_vld),
    .out_side      (t_side),
    .out_wall      (t_wall),
    .out_ceil      (t_ceil),
    .out_trow      (t_trow)
  );

  logic [31:0]          tex_mem [0:STORE_WORDS-1];
  logic [FACE_BITS-1:0] face_sel;
  logic [ADDR_BITS-1:0] raddr;
  logic [ADDR_BITS-1:0] waddr;
  logic                 wr_en;

  assign face_sel = FACE_BITS'(32'(t_side.face) % NUM_TEXTURES);
  assign raddr    = {face_sel, t_trow, t_side.wall_hit[15 -: TEX_BITS]};
  assign waddr    = {face_sel, t_side.texel_index[INDEX_BITS-1:0]};
  assign wr_en    = adv && t_vld && (t_side.action == ACT_WRITE) &&
                    (32'(t_side.texel_index) < TEX_SIZE * TEX_SIZE);

  logic [31:0] rd_r;
  logic        wall_r;
  logic [23:0] flat_r;
  logic [10:0] col_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tex_mem[waddr] <= t_side.texel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= tex_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r  <= t_side.column;
      wall_r <= (t_side.action == ACT_RENDER) && t_wall;
      if (t_side.action == ACT_WRITE) begin
        flat_r <= '0;
      end else if (t_ceil) begin
        flat_r <= ceiling_color_r;
      end else begin
        flat_r <= floor_color_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_column = col_r;
  assign out_in_wall      = wall_r;
  assign out_pixel_color  = wall_r ? rd_r : {8'b0, flat_r};
endmodule
`default_nettype wire
